FILE: design/modexp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, the modulus reset value and the default exponent width.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int MOD_W   = 31;
  localparam int BASE_W  = 32;
  localparam int EXP_W   = 63;
  localparam int PROD_W  = 2 * MOD_W;

  localparam int EXP_WIDTH_DEF = 63;

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

endpackage
`default_nettype wire

FILE: design/modexp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the operand items and the result items.
// ----------------------------------------------------------------------------
interface modexp_in_if
  import modexp_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  logic [EXP_W-1:0]  exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink (input valid, input base, input exponent, output ready);
endinterface

interface modexp_out_if
  import modexp_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] power;

  modport source (output valid, output power, input ready);
  modport sink (input valid, input power, output ready);
endinterface
`default_nettype wire

FILE: design/modexp_modred.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular reduction unit
// Restoring remainder of a double-width value by the modulus, two bits a cycle.
// ----------------------------------------------------------------------------
module modexp_modred
  import modexp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [MOD_W-1:0]  modulus,
  output logic                   done,
  output logic [MOD_W-1:0]       remainder
);

  localparam int STEPS = PROD_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] div_r;
  logic [MOD_W-1:0]  rem_r;

  logic [MOD_W:0]    t1;
  logic [MOD_W:0]    t2;
  logic [MOD_W-1:0]  s1;
  logic [MOD_W-1:0]  s2;

  always_comb begin
    t1 = {rem_r, div_r[PROD_W-1]};
    s1 = (t1 >= {1'b0, modulus}) ? MOD_W'(t1 - {1'b0, modulus}) : t1[MOD_W-1:0];
    t2 = {s1, div_r[PROD_W-2]};
    s2 = (t2 >= {1'b0, modulus}) ? MOD_W'(t2 - {1'b0, modulus}) : t2[MOD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        div_r  <= dividend;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= s2;
        div_r <= div_r << 2;
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

FILE: design/modular_exponentiation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Right-to-left square and multiply of base to the power exponent mod modulus.
// ----------------------------------------------------------------------------
// Usage: an operand transfer on in_if carries base and exponent; one result
// transfer on out_if returns power = base^exponent mod modulus. The modulus
// is to be written through cfg_we/cfg_wdata only while the block is idle; the
// block itself does not enforce this. A modulus of zero gives a result of zero.
// One item is processed at a time and in_if.ready is low while it is in work.
// All arithmetic runs on one 31x31 multiplier and one remainder unit that
// retires two dividend bits per cycle. The base is reduced first; then every
// exponent bit up to the highest set bit takes a check and a squaring, and
// every set bit a multiply as well, less the squaring after the highest set
// bit. A zero exponent ends after the base reduction and its check, and a
// zero modulus goes straight to the result. out_if.valid rises once the
// output register is free.
// A finished result sits in the output register until it is taken; a new item
// can be accepted meanwhile, and a second result waits until the first one
// leaves. Reset returns the sequencer to idle, drops out_if.valid and loads
// the modulus with 1000000007.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
  import modexp_pkg::*;
#(
  parameter int EXP_WIDTH = EXP_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [MOD_W-1:0] cfg_wdata,
  modexp_in_if.sink             in_if,
  modexp_out_if.source          out_if
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_CHECK,
    S_RED_R,
    S_RED_X,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [MOD_W-1:0]     mod_r;
  logic [MOD_W-1:0]     x_r;
  logic [MOD_W-1:0]     r_r;
  logic [EXP_WIDTH-1:0] e_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 start_r;
  logic [MOD_W-1:0]     power_r;
  logic                 out_valid_r;

  logic [MOD_W-1:0]     mul_a;
  logic [PROD_W-1:0]    mul_p;
  logic                 red_done;
  logic [MOD_W-1:0]     red_rem;
  logic                 out_free;

  assign mul_a    = (state_r == S_CHECK && e_r[0]) ? r_r : x_r;
  assign mul_p    = {{MOD_W{1'b0}}, mul_a} * {{MOD_W{1'b0}}, x_r};
  assign out_free = !out_valid_r || out_if.ready;

  modexp_modred u_modred (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .dividend  (prod_r),
    .modulus   (mod_r),
    .done      (red_done),
    .remainder (red_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= MOD_RESET;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      start_r <= 1'b0;
      if (cfg_we) begin
        mod_r <= cfg_wdata;
      end
      if (out_valid_r && out_if.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            e_r <= in_if.exponent[EXP_WIDTH-1:0];
            if (mod_r == '0) begin
              r_r     <= '0;
              state_r <= S_DONE;
            end else begin
              r_r     <= (mod_r == MOD_W'(1)) ? '0 : MOD_W'(1);
              prod_r  <= {{(PROD_W - BASE_W){1'b0}}, in_if.base};
              start_r <= 1'b1;
              state_r <= S_BASE;
            end
          end
        end
        S_BASE: begin
          if (red_done) begin
            x_r     <= red_rem;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (e_r == '0) begin
            state_r <= S_DONE;
          end else begin
            prod_r  <= mul_p;
            start_r <= 1'b1;
            state_r <= e_r[0] ? S_RED_R : S_RED_X;
          end
        end
        S_RED_R: begin
          if (red_done) begin
            r_r <= red_rem;
            if ((e_r >> 1) == '0) begin
              state_r <= S_DONE;
            end else begin
              prod_r  <= mul_p;
              start_r <= 1'b1;
              state_r <= S_RED_X;
            end
          end
        end
        S_RED_X: begin
          if (red_done) begin
            x_r     <= red_rem;
            e_r     <= e_r >> 1;
            state_r <= S_CHECK;
          end
        end
        S_DONE: begin
          if (out_free) begin
            power_r     <= r_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.power = power_r;

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base and exponent operands to the block under several moduli, among
// them the largest, the smallest and the degenerate values one and zero.
// A scoreboard computes each expected power by square and multiply and checks
// every result transfer in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  import modexp_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  class modexp_scoreboard;
    bit [MOD_W-1:0] modulus;
    bit [MOD_W-1:0] powers_due[$];
    int errors;

    function new();
      modulus = MOD_RESET;
      errors = 0;
    endfunction

    function void set_modulus(bit [MOD_W-1:0] value);
      modulus = value;
    endfunction

    function bit [MOD_W-1:0] power_mod(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e);
      bit [63:0] m;
      bit [63:0] sq;
      bit [63:0] acc;
      m = 64'(modulus);
      if (m == 0) begin
        return '0;
      end
      sq = 64'(b) % m;
      acc = 64'd1 % m;
      for (int i = 0; i < EXP_W; i++) begin
        if (e[i]) begin
          acc = (acc * sq) % m;
        end
        sq = (sq * sq) % m;
      end
      return acc[MOD_W-1:0];
    endfunction

    function void note_input(bit [BASE_W-1:0] b, bit [EXP_W-1:0] e);
      powers_due.push_back(power_mod(b, e));
    endfunction

    function void check_result(bit [MOD_W-1:0] power);
      bit [MOD_W-1:0] want;
      if (powers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual power %0d", $time, power);
        errors++;
        return;
      end
      want = powers_due.pop_front();
      if (power !== want) begin
        $display("%0t: power mismatch, expected %0d, actual %0d", $time, want, power);
        errors++;
      end
    endfunction

    function int pending();
      return powers_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [MOD_W-1:0] cfg_wdata = '0;

  modexp_in_if in_ch ();
  modexp_out_if out_ch ();

  modular_exponentiation_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if(in_ch),
    .out_if(out_ch)
  );

  modexp_scoreboard sb = new();
  int cycles = 0;
  int rx_hold = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;

  always #1 clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(20, 200);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (rx_quiet || $urandom_range(0, 3) != 0) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= 1'b0;
      rx_hold <= idle_len();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.power);
    end
  end

  task automatic send_operands(input logic [BASE_W-1:0] b, input logic [EXP_W-1:0] e);
    int gap;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.base <= b;
    in_ch.exponent <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(b, e);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] value);
    drain();
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_modulus(value);
  endtask

  task automatic send_random(input int count);
    logic [BASE_W-1:0] b;
    logic [EXP_W-1:0] e;
    int w;
    tx_quiet = ($urandom_range(0, 3) == 0);
    rx_quiet = ($urandom_range(0, 3) == 0);
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: b = '0;
        1: b = '1;
        2: b = BASE_W'(sb.modulus);
        3: b = BASE_W'(sb.modulus) - 1;
        4: b = $urandom_range(0, 15);
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 19))
        0: e = '0;
        1, 2, 3: e = EXP_W'({$urandom, $urandom});
        4: e = '1;
        default: begin
          w = $urandom_range(1, 16);
          e = EXP_W'($urandom) & ((EXP_W'(1) << w) - 1);
        end
      endcase
      send_operands(b, e);
    end
  endtask

  initial begin
    logic [MOD_W-1:0] moduli[8];
    in_ch.valid = 1'b0;
    in_ch.base = '0;
    in_ch.exponent = '0;
    moduli[0] = 31'd2;
    moduli[1] = 31'h7FFF_FFFF;
    moduli[2] = 31'd1;
    moduli[3] = 31'd0;
    moduli[4] = 31'd3;
    moduli[5] = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
    moduli[6] = 31'd65537;
    moduli[7] = MOD_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_operands(32'd0, 63'd0);
    send_operands(32'd0, 63'd1);
    send_operands(32'd1, 63'h7FFF_FFFF_FFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 63'd0);
    send_operands(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
    send_operands(32'd1000000007, 63'd5);
    send_operands(32'd1000000006, 63'd2);
    send_operands(32'd2, 63'd1000000006);
    send_operands(32'd3, 63'h4000_0000_0000_0000);
    send_operands(32'hAAAA_AAAA, 63'h5555_5555_5555_5555);
    send_operands(32'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
    send_operands(32'h8000_0000, 63'd1);
    send_operands(32'd7, 63'd2);
    send_random(12);

    foreach (moduli[i]) begin
      write_modulus(moduli[i]);
      send_operands(32'd0, 63'd0);
      send_random(12);
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
